@@ sv/xs256_pkg.sv @@
// Shared types, constants and helpers for the xoshiro256** generator.
// No dependencies; imported by xs256_mul, xoshiro256ss_generator_unit and the testbench files.
package xs256_pkg;

	typedef logic [63:0] word_t;

	localparam word_t SM_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
	localparam word_t SM_MIX1   = 64'hbf58_476d_1ce4_e5b9;
	localparam word_t SM_MIX2   = 64'h94d0_49bb_1331_11eb;

	localparam int unsigned NUM_WORDS = 4;
	localparam int unsigned SHIFT_T   = 17;
	localparam int unsigned ROT_OUT   = 7;
	localparam int unsigned ROT_S3    = 45;

	// request to the shared 64x64 (low half) multiplier
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mul_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t product;
	} mul_rsp_t;

	function automatic word_t rotl(input word_t v, input int unsigned amt);
		word_t r;
		if (amt % 64 == 0) begin
			r = v;
		end else begin
			r = (v << (amt % 64)) | (v >> (64 - (amt % 64)));
		end
		return r;
	endfunction

endpackage

@@ sv/xs256_mul.sv @@
// Iterative 64x64 multiplier keeping the low 64 bits, built on one 32x32 unit.
// Depends on xs256_pkg.
module xs256_mul
	import xs256_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [1:0]  cnt_q;
	word_t       a_q;
	word_t       b_q;
	word_t       pp_q;
	word_t       acc_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	word_t       pp_d;

	// lo*lo, lo*hi, hi*lo; hi*hi falls outside the low 64 bits
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
			2'd1: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			default: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
		endcase
		pp_d = {32'd0, op_a} * {32'd0, op_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			pp_q <= pp_d;
			case (cnt_q)
				2'd1:    acc_q <= pp_q;
				2'd2:    acc_q[63:32] <= acc_q[63:32] + pp_q[31:0];
				2'd3:    acc_q[63:32] <= acc_q[63:32] + pp_q[31:0];
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q && cnt_q == 2'd3))
		else $error("multiplier done without finishing its last pass");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiplier started while busy");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == 2'd0)
		else $error("multiplier pass count left nonzero while idle");

endmodule

@@ sv/xoshiro256ss_generator_unit.sv @@
// Next item: the unit moves to ST_NEXT and registers the result there once the output reg is free.
// Seed item: four SplitMix64 rounds, bound by the shared iterative multiplier
// (two products per round).
// The input is not ready while an item is in progress; a result waits in an output reg.
// Reset clears the four state words, so unseeded next items return zero.
// Depends on xs256_pkg and xs256_mul.
module xoshiro256ss_generator_unit
	import xs256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [63:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] random_value
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_SM_MUL1,
		ST_SM_W1,
		ST_SM_W2
	} state_t;

	localparam logic OP_SEED = 1'b0;

	state_t     state_q;
	word_t      gen_q [NUM_WORDS];
	word_t      m5_q;
	word_t      sm_q;
	logic [1:0] word_cnt_q;
	logic       out_valid_q;
	word_t      random_value_q;

	mul_req_t   mul_req;
	mul_rsp_t   mul_rsp;
	logic       in_take;
	logic       out_free;
	word_t      rot_m5;
	word_t      result_d;
	word_t      n0;
	word_t      n1;
	word_t      n2;
	word_t      n3;
	word_t      mix_done;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// output mix, xoshiro state update and the SplitMix64 final xor-shift
	always_comb begin
		rot_m5   = rotl(m5_q, ROT_OUT);
		result_d = rot_m5 + (rot_m5 << 3);
		n2 = gen_q[2] ^ gen_q[0];
		n3 = gen_q[3] ^ gen_q[1];
		n1 = gen_q[1] ^ n2;
		n0 = gen_q[0] ^ n3;
		n2 = n2 ^ (gen_q[1] << SHIFT_T);
		n3 = rotl(n3, ROT_S3);
		mix_done = mul_rsp.product ^ (mul_rsp.product >> 31);
	end

	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = sm_q ^ (sm_q >> 30);
		mul_req.b     = SM_MIX1;
		if (state_q == ST_SM_MUL1) begin
			mul_req.start = 1'b1;
		end else if (state_q == ST_SM_W1) begin
			mul_req.start = mul_rsp.done;
			mul_req.a     = mul_rsp.product ^ (mul_rsp.product >> 27);
			mul_req.b     = SM_MIX2;
		end
	end

	xs256_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			word_cnt_q  <= 2'd0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				gen_q[i] <= '0;
			end
		end else begin
			// a new result may replace one taken in the same cycle
			if (state_q == ST_NEXT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (operation == OP_SEED) begin
							word_cnt_q <= 2'd0;
							state_q    <= ST_SM_MUL1;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (out_free) begin
						gen_q[0]    <= n0;
						gen_q[1]    <= n1;
						gen_q[2]    <= n2;
						gen_q[3]    <= n3;
						state_q     <= ST_IDLE;
					end
				end
				ST_SM_MUL1: begin
					state_q <= ST_SM_W1;
				end
				ST_SM_W1: begin
					if (mul_rsp.done) begin
						state_q <= ST_SM_W2;
					end
				end
				ST_SM_W2: begin
					if (mul_rsp.done) begin
						gen_q[word_cnt_q] <= mix_done;
						word_cnt_q        <= word_cnt_q + 2'd1;
						if (word_cnt_q == 2'(NUM_WORDS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SM_MUL1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			m5_q <= gen_q[1] + (gen_q[1] << 2);
			sm_q <= seed_value + SM_GOLDEN;
		end else if (state_q == ST_SM_W2 && mul_rsp.done) begin
			sm_q <= sm_q + SM_GOLDEN;
		end
		if (state_q == ST_NEXT && out_free) begin
			random_value_q <= result_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;

	a_result_only_from_next: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_NEXT))
		else $error("result raised outside a next transaction");

	a_mul_done_in_seed: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_SM_W1 || state_q == ST_SM_W2))
		else $error("multiplier result arrived outside seeding");

	a_seed_ends_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SM_W2 && mul_rsp.done && word_cnt_q == 2'd3) |=>
			(state_q == ST_IDLE && word_cnt_q == 2'd0))
		else $error("seeding ended without filling all state words");

endmodule

@@ tb/xoshiro256ss_checker.sv @@
// Operation codes for the testbench, plus a checker that predicts xoshiro256** results.
// The checker watches both channels and compares each result with its prediction.
// Depends on xs256_pkg for word_t and the SplitMix64/xoshiro constants.
package xs256_tb_pkg;

	typedef enum logic {
		OP_SEED = 1'b0,
		OP_NEXT = 1'b1
	} xs_op_e;

endpackage

module xoshiro256ss_checker
	import xs256_pkg::*;
	import xs256_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [63:0] seed_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] random_value,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	word_t gen_state [NUM_WORDS];
	word_t expected_values [$];

	function automatic word_t rot_up(input word_t v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	// four SplitMix64 rounds fill the state words in order
	task automatic load_seed(input word_t s);
		word_t z;
		for (int n = 0; n < NUM_WORDS; n++) begin
			s = s + SM_GOLDEN;
			z = s;
			z = (z ^ (z >> 30)) * SM_MIX1;
			z = (z ^ (z >> 27)) * SM_MIX2;
			gen_state[n] = z ^ (z >> 31);
		end
	endtask

	task automatic advance_state(output word_t r);
		word_t t;
		r = rot_up(gen_state[1] * 64'd5, ROT_OUT) * 64'd9;
		t = gen_state[1] << SHIFT_T;
		gen_state[2] ^= gen_state[0];
		gen_state[3] ^= gen_state[1];
		gen_state[1] ^= gen_state[2];
		gen_state[0] ^= gen_state[3];
		gen_state[2] ^= t;
		gen_state[3] = rot_up(gen_state[3], ROT_S3);
	endtask

	// input acceptance is handled before output so a same-edge result still finds its entry
	always @(posedge clk or negedge arst_n) begin
		word_t predicted;
		word_t oldest;
		if (!arst_n) begin
			for (int n = 0; n < NUM_WORDS; n++)
				gen_state[n] = '0;
			expected_values.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (operation == OP_SEED) begin
					load_seed(seed_value);
				end else begin
					advance_state(predicted);
					expected_values.push_back(predicted);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result transaction random_value=%h",
							$realtime, random_value);
				end else begin
					oldest = expected_values.pop_front();
					if (oldest !== random_value) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: random_value mismatch: expected %h, got %h",
								$realtime, oldest, random_value);
					end
				end
			end
			pending <= expected_values.size();
		end
	end

endmodule

@@ tb/xoshiro256ss_generator_unit_tb.sv @@
// Top of the xoshiro256** generator testbench: clock, reset, stimulus and verdict.
// Depends on xs256_pkg, xs256_tb_pkg and xoshiro256ss_checker, plus the RTL.
module xoshiro256ss_generator_unit_tb;
	import xs256_pkg::*;
	import xs256_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ITEMS_PER_PHASE = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [63:0] seed_value;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] random_value;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;

	xoshiro256ss_generator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_value (random_value)
	);

	xoshiro256ss_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_value (random_value),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_item(input xs_op_e op, input word_t seed);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		seed_value <= seed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic word_t any_word();
		return {$urandom, $urandom};
	endfunction

	initial begin
		in_valid     = 1'b0;
		operation    = OP_NEXT;
		seed_value   = '0;
		arst_n       = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unseeded state gives zeros; seed_value must be ignored by next items
		send_item(OP_NEXT, '1);
		send_item(OP_NEXT, '0);
		send_item(OP_SEED, '0);
		repeat (3) send_item(OP_NEXT, any_word());
		send_item(OP_SEED, '1);
		repeat (2) send_item(OP_NEXT, '1);
		send_item(OP_SEED, 64'h8000_0000_0000_0000);
		send_item(OP_NEXT, '0);
		send_item(OP_SEED, 64'd1);
		send_item(OP_NEXT, 64'h5555_5555_5555_5555);
		// back-to-back seeds: only the last one counts
		send_item(OP_SEED, 64'h5555_5555_5555_5555);
		send_item(OP_SEED, 64'haaaa_aaaa_aaaa_aaaa);
		repeat (2) send_item(OP_NEXT, 64'haaaa_aaaa_aaaa_aaaa);
		send_item(OP_SEED, 64'h61c8_8646_80b5_83eb);
		repeat (2) send_item(OP_NEXT, any_word());

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(9) == 0)
					send_item(OP_SEED, any_word());
				else
					send_item(OP_NEXT, any_word());
			end
		end

		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
